/* design/p2alc_pkg.sv */
// ----------------------------------------------------------------------------
// p2alc_pkg
// Shared types and constants of the power-of-two size-class block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package p2alc_pkg;

  // geometry of the allocator
  localparam int MIN_BLOCK   = 64;
  localparam int FREE_DEPTH  = 64;
  localparam int CLASS_COUNT = 27;

  // fixed field widths
  localparam int LEN_W    = 32;
  localparam int OFF_W    = 32;
  localparam int REGION_W = 33;
  localparam int BS_W     = 34;
  localparam int STAT_W   = 3;

  // stream packing
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - OFF_W - BS_W;

  // derived sizes
  localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int MEM_DEPTH = CLASS_COUNT * FREE_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W     = $clog2(FREE_DEPTH + 1);

  // classification queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_REUSED       = 3'd0,
    ST_BUMP         = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_FREED        = 3'd3,
    ST_DROPPED      = 3'd4,
    ST_OUT_OF_RANGE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_CLASS,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_POP,
    B_BUMP,
    B_DONE
  } back_state_t;

  // one classified request
  typedef struct packed {
    logic              cmd;
    logic [OFF_W-1:0]  offset;
    logic              out_of_range;
    logic              has_stack;
    logic [CLS_W-1:0]  cls;
    logic [MEM_AW-1:0] base;
    logic [BS_W-1:0]   block_size;
  } item_t;

  // queue handshake toward the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

/* design/p2alc_ram.sv */
// ----------------------------------------------------------------------------
// p2alc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module p2alc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/p2alc_front.sv */
// ----------------------------------------------------------------------------
// p2alc_front
// Accepts requests, finds the size class and range status, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module p2alc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [p2alc_pkg::REGION_W-1:0] region_size,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [p2alc_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [0:0]                     s_tuser,
  input  p2alc_pkg::q_status_t           q_status,
  output logic                           q_push,
  output p2alc_pkg::item_t               q_item
);

  import p2alc_pkg::*;

  localparam int M_W     = LEN_W + 1;
  localparam int NCHUNK  = (M_W + 7) / 8;
  localparam int PAD_W   = NCHUNK * 8;
  localparam int E_W     = $clog2(BS_W);
  localparam int LOG_MIN = $clog2(MIN_BLOCK);
  localparam int HDR_BYTES = 4;
  localparam int NUL_BYTES = 1;

  function automatic logic [3:0] bitlen8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  front_state_t state, state_next;

  logic             cmd;
  logic [LEN_W-1:0] len;
  logic [OFF_W-1:0] off;
  logic             oor;
  logic [NCHUNK-1:0] chunk_nz;
  logic [3:0]       chunk_len [NCHUNK];
  item_t            item;

  logic accept;

  // scan stage: needed bytes minus one, floored at the minimum block minus one
  logic [M_W-1:0]   need_m1;
  logic [M_W-1:0]   m_val;
  logic [PAD_W-1:0] m_pad;

  assign need_m1 = {1'b0, len} + M_W'(HDR_BYTES + NUL_BYTES - 1);
  assign m_val   = (need_m1 < M_W'(MIN_BLOCK - 1)) ? M_W'(MIN_BLOCK - 1) : need_m1;
  assign m_pad   = PAD_W'(m_val);

  // class stage: exponent from the highest nonzero byte
  logic [E_W-1:0] expo;
  logic [6:0]     cls_full;
  logic [CLS_W-1:0] cls;

  always_comb begin
    expo = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (chunk_nz[c]) begin
        expo = E_W'(c * 8) + E_W'(chunk_len[c]);
      end
    end
  end

  assign cls_full = 7'(expo) - 7'(LOG_MIN);
  assign cls      = CLS_W'(cls_full);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (s_tvalid) state_next = F_SCAN;
      F_SCAN:  state_next = F_CLASS;
      F_CLASS: state_next = F_PUSH;
      F_PUSH:  if (!q_status.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    q_push   = 1'b0;
    case (state)
      F_IDLE:  s_tready = 1'b1;
      F_PUSH:  q_push   = !q_status.full;
      default: begin
        s_tready = 1'b0;
        q_push   = 1'b0;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= s_tuser[0];
      len <= s_tdata[LEN_W-1:0];
      off <= s_tdata[LEN_W +: OFF_W];
    end
    if (state == F_SCAN) begin
      oor <= {1'b0, off} >= region_size;
      for (int c = 0; c < NCHUNK; c++) begin
        chunk_nz[c]  <= |m_pad[c*8 +: 8];
        chunk_len[c] <= bitlen8(m_pad[c*8 +: 8]);
      end
    end
    if (state == F_CLASS) begin
      item.cmd          <= cmd;
      item.offset       <= off;
      item.out_of_range <= oor;
      item.has_stack    <= int'(cls_full) < CLASS_COUNT;
      item.cls          <= cls;
      item.base         <= MEM_AW'(int'(cls) * FREE_DEPTH);
      item.block_size   <= BS_W'(1) << expo;
    end
  end

endmodule

`default_nettype wire

/* design/p2alc_queue.sv */
// ----------------------------------------------------------------------------
// p2alc_queue
// Short queue of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module p2alc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  p2alc_pkg::item_t     push_item,
  input  logic                 pop,
  output p2alc_pkg::q_status_t status,
  output p2alc_pkg::item_t     head
);

  import p2alc_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* design/p2alc_back.sv */
// ----------------------------------------------------------------------------
// p2alc_back
// Carries out allocate and free requests on the class stacks and bump pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module p2alc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [p2alc_pkg::REGION_W-1:0]  region_size,
  input  p2alc_pkg::q_status_t            q_status,
  input  p2alc_pkg::item_t                q_head,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [p2alc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [p2alc_pkg::STAT_W-1:0]    m_tuser
);

  import p2alc_pkg::*;

  back_state_t state, state_next;

  item_t                item;
  logic [CNT_W-1:0]     counts [CLASS_COUNT];
  logic [REGION_W-1:0]  bump;
  logic [BS_W-1:0]      aligned;
  status_t              res_status;
  logic [OFF_W-1:0]     res_off;

  logic [CNT_W-1:0]  cnt;
  logic              pop_hit;
  logic              push_ok;
  logic              ram_we;
  logic              ram_re;
  logic [MEM_AW-1:0] ram_waddr;
  logic [MEM_AW-1:0] ram_raddr;
  logic [OFF_W-1:0]  ram_rdata;
  logic              out_load;

  logic [BS_W-1:0]   blk_m1;
  logic [BS_W-1:0]   aligned_sum;
  logic [BS_W:0]     end_sum;
  logic              fits;

  assign cnt     = item.has_stack ? counts[item.cls] : '0;
  assign pop_hit = (item.cmd == CMD_ALLOC) && item.has_stack && (cnt != '0);
  assign push_ok = (item.cmd == CMD_FREE) && !item.out_of_range && item.has_stack &&
                   (cnt < CNT_W'(FREE_DEPTH));

  // align up to the block size
  assign blk_m1      = item.block_size - BS_W'(1);
  assign aligned_sum = {1'b0, bump} + blk_m1;
  assign end_sum     = {1'b0, aligned} + {1'b0, item.block_size};
  assign fits        = end_sum <= (BS_W + 1)'(region_size);

  assign ram_waddr = item.base + MEM_AW'(cnt);
  assign ram_raddr = item.base + MEM_AW'(cnt) - MEM_AW'(1);

  p2alc_ram #(
    .WIDTH (OFF_W),
    .DEPTH (MEM_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.offset),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!q_status.empty) state_next = B_EXEC;
      B_EXEC: begin
        if (pop_hit) begin
          state_next = B_POP;
        end else if (item.cmd == CMD_ALLOC) begin
          state_next = B_BUMP;
        end else begin
          state_next = B_DONE;
        end
      end
      B_POP:  state_next = B_DONE;
      B_BUMP: state_next = B_DONE;
      B_DONE: if (!m_tvalid || m_tready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    case (state)
      B_IDLE: q_pop = !q_status.empty;
      B_EXEC: begin
        ram_re = pop_hit;
        ram_we = push_ok;
      end
      B_DONE: out_load = !m_tvalid || m_tready;
      default: begin
        q_pop    = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      bump     <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == B_EXEC) begin
        if (pop_hit) begin
          counts[item.cls] <= cnt - 1'b1;
        end else if (push_ok) begin
          counts[item.cls] <= cnt + 1'b1;
        end
      end
      if (state == B_BUMP && fits) begin
        bump <= end_sum[REGION_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_head;
    end
    case (state)
      B_EXEC: begin
        aligned <= aligned_sum & ~blk_m1;
        res_off <= '0;
        if (item.out_of_range) begin
          res_status <= ST_OUT_OF_RANGE;
        end else if (push_ok) begin
          res_status <= ST_FREED;
        end else begin
          res_status <= ST_DROPPED;
        end
      end
      B_POP: begin
        res_status <= ST_REUSED;
        res_off    <= ram_rdata;
      end
      B_BUMP: begin
        if (fits) begin
          res_status <= ST_BUMP;
          res_off    <= aligned[OFF_W-1:0];
        end else begin
          res_status <= ST_NO_SPACE;
          res_off    <= '0;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, item.block_size, res_off};
      m_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire

/* design/pow2_size_class_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// pow2_size_class_block_allocator_unit
// Power-of-two size-class allocator with per-class free stacks and bump fill.
// ----------------------------------------------------------------------------
// Each request returns exactly one response. The front sequencer captures a
// request and then steps through a byte scan of the length, a class pick and
// a queue push, which waits while the queue is full; it takes no new request
// until that push is done. The back end does a queue pop, count lookup,
// free-stack RAM read or alignment compare and output load for an allocation,
// and skips the read or compare step for a free; the output load waits while
// an earlier response is stalled. The two ends overlap through a two-entry
// queue. Class fill counts sit in flip-flops cleared by reset; the free-stack
// RAM needs no clearing pass since only entries below a class's count are ever read.
// region_size may only be written while no request is in flight.
`default_nettype none

module pow2_size_class_block_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [p2alc_pkg::REGION_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [p2alc_pkg::IN_DATA_W-1:0]  s_tdata,   // length, offset
  input  logic [0:0]                       s_tuser,   // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [p2alc_pkg::OUT_DATA_W-1:0] m_tdata,   // block_offset, block_size, zero pad
  output logic [p2alc_pkg::STAT_W-1:0]     m_tuser    // status
);

  import p2alc_pkg::*;

  logic [REGION_W-1:0] region_size;
  q_status_t           q_status;
  item_t               q_in;
  item_t               q_head;
  logic                q_push;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      region_size <= cfg_data;
    end
  end

  p2alc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .region_size (region_size),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  p2alc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .status    (q_status),
    .head      (q_head)
  );

  p2alc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .region_size (region_size),
    .q_status    (q_status),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

/* design/p2alc_checker.sv */
// ----------------------------------------------------------------------------
// p2alc_checker
// Port-level checks on the allocator response stream.
// ----------------------------------------------------------------------------
`default_nettype none

module p2alc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [p2alc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [p2alc_pkg::STAT_W-1:0]     m_tuser
);

  import p2alc_pkg::*;

  logic [OFF_W-1:0] blk_off;
  logic [BS_W-1:0]  blk_size;

  assign blk_off  = m_tdata[OFF_W-1:0];
  assign blk_size = m_tdata[OFF_W +: BS_W];

  // failed and free responses carry no offset
  a_zero_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NO_SPACE || m_tuser == ST_FREED ||
                 m_tuser == ST_DROPPED || m_tuser == ST_OUT_OF_RANGE)
    |-> blk_off == '0)
    else $error("offset nonzero on a response without a block");

  a_pow2_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(blk_size))
    else $error("block size is not a power of two");

  // bump allocations land on a block-size boundary
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_BUMP |-> (({2'b00, blk_off} & (blk_size - 1'b1)) == '0))
    else $error("bump allocation not aligned to its block size");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("response changed while stalled");

endmodule

bind pow2_size_class_block_allocator_unit p2alc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
